// ===== sv/assert_macros.svh =====
// assertion macros shared by the cache rtl
// no dependencies; compiled away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked while out of reset
`define ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion lbl failed");
// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion lbl failed");
`else
`define ASSERT_RST(lbl, clk, rstn, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== sv/lkvc_pkg.sv =====
// types and constants of the lru key-value cache
// no dependencies
`default_nettype none

package lkvc_pkg;

  localparam int unsigned MaxEntriesDef = 16;
  localparam int unsigned CapW          = 5;
  localparam logic [CapW-1:0] CapReset  = 5'd16;

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_PUT = 1'b1
  } lkvc_action_e;

  typedef struct packed {
    lkvc_action_e       action;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } lkvc_in_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] read_value;
  } lkvc_out_t;

  // one stored entry as handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } lkvc_entry_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic               hit;       // accepted beat hit some cell
    logic               put_miss;  // accepted put of a new key
    logic               fill;      // new key takes a free slot
    logic signed [31:0] key;       // lookup key
  } lkvc_ctrl_t;

  localparam logic signed [31:0] MissValue = -32'sd1;

endpackage

`default_nettype wire

// ===== sv/lkvc_cell.sv =====
// one recency position of the cache chain: entry storage and key compare
// depends on lkvc_pkg
`default_nettype none

module lkvc_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lkvc_pkg::lkvc_ctrl_t  ctrl_i,
  input  lkvc_pkg::lkvc_entry_t prev_i,
  input  logic                  seen_i,
  output lkvc_pkg::lkvc_entry_t entry_o,
  output logic                  match_o,
  output logic                  seen_o
);
  import lkvc_pkg::*;

  logic               valid_q, valid_d;
  logic signed [31:0] key_q, key_d;
  logic signed [31:0] value_q, value_d;
  logic               shift;

  assign match_o = valid_q && (key_q == ctrl_i.key);
  assign seen_o  = seen_i | match_o;

  // on a hit, every cell up to the matching one moves one place older;
  // on a new key, occupied cells move and the first free one on a fill
  always_comb begin
    if (ctrl_i.hit) begin
      shift = !seen_i;
    end else begin
      shift = ctrl_i.put_miss && (valid_q || (ctrl_i.fill && prev_i.valid));
    end
    valid_d = shift ? prev_i.valid : valid_q;
    key_d   = shift ? prev_i.key   : key_q;
    value_d = shift ? prev_i.value : value_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign entry_o = '{valid: valid_q, key: key_q, value: value_q};

endmodule

`default_nettype wire

// ===== sv/lkvc_out_buf.sv =====
// result output register with one skid entry
// depends on lkvc_pkg
`default_nettype none

module lkvc_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_valid_i,
  input  lkvc_pkg::lkvc_out_t res_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output lkvc_pkg::lkvc_out_t out_data_o,
  output logic                full_o
);
  import lkvc_pkg::*;

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  lkvc_out_t out_q, out_d;
  lkvc_out_t skid_q, skid_d;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = res_valid_i;
        out_d       = res_i;
      end
    end else if (res_valid_i) begin
      skid_valid_d = 1'b1;
      skid_d       = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign full_o      = skid_valid_q;

endmodule

`default_nettype wire

// ===== sv/lru_key_value_cache.sv =====
// lru key-value cache: chain of recency cells, output register and skid entry
// a taken get result is registered in the output register or the skid entry
// throughput: one beat per cycle unless in_stall_o is high; the whole compare
// and recency shift is one pass through the cell chain, so the next beat sees
// the updated order; reset: all cells empty, occupancy zero, capacity 16;
// depends on lkvc_pkg, lkvc_cell, lkvc_out_buf and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module lru_key_value_cache #(
  parameter int unsigned MAX_ENTRIES = lkvc_pkg::MaxEntriesDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  lkvc_pkg::lkvc_in_t                 in_data_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output lkvc_pkg::lkvc_out_t                out_data_o,
  // capacity register
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lkvc_pkg::CapW-1:0]          cfg_data_i
);
  import lkvc_pkg::*;

  localparam int unsigned OccW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned EffW = (OccW > CapW) ? OccW : CapW;

  // capacity register, always ready
  logic [CapW-1:0] cap_q;
  logic [OccW-1:0] occ_q, occ_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  // zero acts as one, anything past the chain length as the chain length
  logic [EffW-1:0] cap_ext, cap_eff;
  logic            fill;

  always_comb begin
    cap_ext = EffW'(cap_q);
    if (cap_q == '0) begin
      cap_eff = EffW'(1);
    end else if (cap_ext > EffW'(MAX_ENTRIES)) begin
      cap_eff = EffW'(MAX_ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign fill = EffW'(occ_q) < cap_eff;

  // beat handshake
  logic buf_full;
  logic accept;
  logic is_put;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_put     = (in_data_i.action == ACT_PUT);

  // cell chain; position 0 is the most recent entry
  lkvc_entry_t                entries [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]     match_vec;
  logic [MAX_ENTRIES-1:0]     valid_vec;
  logic [MAX_ENTRIES:0]       seen;
  lkvc_ctrl_t                 ctrl;
  lkvc_entry_t                head;
  logic                       any_hit;
  logic signed [31:0]         hit_value;

  assign seen[0] = 1'b0;
  assign any_hit = |match_vec;

  // keys are unique among valid cells, so at most one match
  always_comb begin
    hit_value = '0;
    for (int p = 0; p < MAX_ENTRIES; p++) begin
      if (match_vec[p]) begin
        hit_value = hit_value | entries[p].value;
      end
    end
  end

  assign ctrl = '{
    hit:      accept && any_hit,
    put_miss: accept && is_put && !any_hit,
    fill:     fill,
    key:      in_data_i.key
  };

  // what position 0 takes on any promote
  assign head = '{
    valid: 1'b1,
    key:   in_data_i.key,
    value: is_put ? in_data_i.value : hit_value
  };

  for (genvar p = 0; p < MAX_ENTRIES; p++) begin : g_cell
    lkvc_entry_t prev;
    if (p == 0) begin : g_head
      assign prev = head;
    end else begin : g_link
      assign prev = entries[p-1];
    end

    lkvc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .prev_i  (prev),
      .seen_i  (seen[p]),
      .entry_o (entries[p]),
      .match_o (match_vec[p]),
      .seen_o  (seen[p+1])
    );

    assign valid_vec[p] = entries[p].valid;
  end

  // occupancy grows only when a new key finds a free slot
  always_comb begin
    occ_d = occ_q;
    if (ctrl.put_miss && fill) begin
      occ_d = occ_q + OccW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // result of a get: stored value on hit, all ones on miss
  lkvc_out_t res;
  logic      res_valid;

  assign res_valid = accept && !is_put;
  assign res       = '{found: any_hit, read_value: any_hit ? hit_value : MissValue};

  lkvc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .full_o      (buf_full)
  );

  // a key lives in at most one cell
  `ASSERT_RST(a_single_match, clk_i, rst_ni, $onehot0(match_vec))
  // valid cells track the occupancy count
  `ASSERT_RST(a_occ_count, clk_i, rst_ni, $countones(valid_vec) == int'(occ_q))
  // occupancy never passes the chain length
  `ASSERT_RST(a_occ_max, clk_i, rst_ni, occ_q <= OccW'(MAX_ENTRIES))
  // the skid entry only fills behind a held output beat
  `ASSERT_RST(a_skid_behind, clk_i, rst_ni, in_stall_o |-> out_valid_o)

endmodule

`default_nettype wire
